// ----- rtl/ibs_pkg.sv -----
// ----------------------------------------------------------------------------
// Itinerary search package
// Shared widths, constants and the sequencer state type.
// ----------------------------------------------------------------------------
package ibs_pkg;
	localparam int CodeW = 24;
	localparam int StatusW = 2;
	localparam int DefCapacity = 32;
	localparam logic [CodeW-1:0] DefStart = 24'h49434E;

	localparam logic [StatusW-1:0] StFound = 2'd0;
	localparam logic [StatusW-1:0] StEmpty = 2'd1;
	localparam logic [StatusW-1:0] StNoPath = 2'd2;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_INS    = 14'b00000000000010,
		S_INSW   = 14'b00000000000100,
		S_GO     = 14'b00000000001000,
		S_RD     = 14'b00000000010000,
		S_SCAN   = 14'b00000000100000,
		S_POP    = 14'b00000001000000,
		S_POPW   = 14'b00000010000000,
		S_POPD   = 14'b00000100000000,
		S_SKIP   = 14'b00001000000000,
		S_EMIT   = 14'b00010000000000,
		S_EMS    = 14'b00100000000000,
		S_EMD    = 14'b01000000000000,
		S_STAT   = 14'b10000000000000
	} state_t;
endpackage

// ----- rtl/itinerary_backtracking_search.sv -----
// ----------------------------------------------------------------------------
// Itinerary backtracking search
// Loads tickets with a sorted insert, then searches depth first for a path
// that uses every ticket and streams the visited airports.
// ----------------------------------------------------------------------------
// A ticket item steps through S_INS and S_INSW, where table entries move up
// one at a time for the sorted insert, then S_GO; an item without a ticket
// goes straight to S_GO. The final item runs the search: one table entry is
// compared per cycle by a single compare unit, and each backtrack pops the
// stack, frees its ticket and skips entries of equal destination. Results
// go out via S_EMIT, S_EMS and S_EMD (the start airport via S_EMIT only), a
// status via S_STAT. Input is not ready during insert, search or result output.
module itinerary_backtracking_search #(
	parameter int TICKET_CAPACITY = ibs_pkg::DefCapacity
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // origin_code, dest_code
	input  logic        s_axis_tuser,  // ticket_present
	input  logic        s_axis_tlast,  // final_item
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // airport_code, status, dropped, zero pad
	output logic        m_axis_tlast   // end_of_path
);
	import ibs_pkg::*;
	localparam int IW = $clog2(TICKET_CAPACITY + 1);
	localparam int AW = (TICKET_CAPACITY > 1) ? $clog2(TICKET_CAPACITY) : 1;
	localparam logic [IW-1:0] Cap = IW'(TICKET_CAPACITY);

	state_t state_q;
	logic [CodeW-1:0] start_q, org_q, dst_q, cur_q, skipd_q, rd_org_q, rd_dst_q;
	logic [CodeW-1:0] org_mem [TICKET_CAPACITY];
	logic [CodeW-1:0] dst_mem [TICKET_CAPACITY];
	logic [AW-1:0] stk_mem [TICKET_CAPACITY];
	logic [TICKET_CAPACITY-1:0] used_q;
	logic [IW-1:0] cnt_q, pos_q, idx_q, dep_q;
	logic [AW-1:0] stk_rd_q;
	logic ovf_q, fin_q, ov_q, olast_q, dropped_q;
	logic [CodeW-1:0] ocode_q;
	logic [StatusW-1:0] ost_q, stat_q;

	// memory ports
	logic we;
	logic [AW-1:0] wa, ra, sra;
	logic [CodeW-1:0] wo, wd;
	logic swe;

	logic out_free, out_load, hit, ins_stop, emit_last;

	always_ff @(posedge clk) begin
		if (we) begin
			org_mem[wa] <= wo;
			dst_mem[wa] <= wd;
		end
		rd_org_q <= org_mem[ra];
		rd_dst_q <= dst_mem[ra];
		if (swe) stk_mem[dep_q[AW-1:0]] <= idx_q[AW-1:0];
		stk_rd_q <= stk_mem[sra];
	end

	assign out_free = !ov_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {5'd0, dropped_q, ost_q, ocode_q};
	assign m_axis_tlast = olast_q;

	assign hit = (rd_org_q == cur_q) && !used_q[idx_q[AW-1:0]];
	assign ins_stop = (pos_q == '0) || !(rd_dst_q > dst_q);
	assign emit_last = (dep_q == cnt_q);

	always_comb begin
		we = 1'b0; wa = pos_q[AW-1:0]; wo = rd_org_q; wd = rd_dst_q; swe = 1'b0;
		ra = idx_q[AW-1:0];
		sra = AW'(dep_q - 1'b1);
		out_load = 1'b0;
		unique case (state_q)
			S_INS:  ra = AW'(pos_q - 1'b1);
			S_INSW: begin
				we = 1'b1;
				if (ins_stop) begin
					wo = org_q; wd = dst_q;
				end
				ra = AW'(pos_q - 2'd2);
			end
			S_SCAN: begin
				ra = AW'(idx_q + 1'b1);
				swe = (idx_q < cnt_q) && hit;
			end
			S_SKIP: ra = AW'(idx_q + 1'b1);
			S_POP:  sra = dep_q[AW-1:0];
			S_POPW: ra = stk_rd_q;
			S_EMS:  ra = stk_rd_q;
			S_EMD: begin
				ra = stk_rd_q;
				out_load = out_free;
			end
			S_EMIT: out_load = out_free && (dep_q == '0);
			S_STAT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; start_q <= DefStart; used_q <= '0;
			cnt_q <= '0; pos_q <= '0; idx_q <= '0; dep_q <= '0;
			ovf_q <= 1'b0; fin_q <= 1'b0; ov_q <= 1'b0; dropped_q <= 1'b0;
			olast_q <= 1'b0; ocode_q <= '0; ost_q <= '0; org_q <= '0; dst_q <= '0;
			cur_q <= '0; skipd_q <= '0; stat_q <= '0;
		end else begin
			if (cfg_we) start_q <= cfg_wdata;
			if (out_load) begin
				ov_q <= 1'b1;
				dropped_q <= ovf_q;
				if (state_q == S_EMD) begin
					ocode_q <= rd_dst_q; ost_q <= StFound; olast_q <= emit_last;
				end else if (state_q == S_EMIT) begin
					ocode_q <= start_q; ost_q <= StFound; olast_q <= 1'b0;
				end else begin
					ocode_q <= '0; ost_q <= stat_q; olast_q <= 1'b1;
				end
			end else if (m_axis_tready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					org_q <= s_axis_tdata[23:0];
					dst_q <= s_axis_tdata[47:24];
					fin_q <= s_axis_tlast;
					pos_q <= cnt_q;
					if (s_axis_tuser && cnt_q < Cap) state_q <= S_INS;
					else begin
						if (s_axis_tuser) ovf_q <= 1'b1;
						state_q <= S_GO;
					end
				end
				S_INS: state_q <= S_INSW;
				S_INSW: begin
					if (ins_stop) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_GO;
					end else pos_q <= pos_q - 1'b1;
				end
				S_GO: begin
					if (!fin_q) state_q <= S_IDLE;
					else if (cnt_q == '0) begin
						stat_q <= StEmpty; state_q <= S_STAT;
					end else begin
						dep_q <= '0; idx_q <= '0; cur_q <= start_q;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (dep_q >= cnt_q) begin
						dep_q <= '0; state_q <= S_EMIT;
					end else state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (idx_q >= cnt_q) begin
						if (dep_q == '0) begin
							stat_q <= StNoPath; state_q <= S_STAT;
						end else begin
							dep_q <= dep_q - 1'b1; state_q <= S_POP;
						end
					end else if (hit) begin
						used_q[idx_q[AW-1:0]] <= 1'b1;
						dep_q <= dep_q + 1'b1;
						cur_q <= rd_dst_q;
						idx_q <= '0;
						state_q <= S_RD;
					end else idx_q <= idx_q + 1'b1;
				end
				S_POP: state_q <= S_POPW;
				S_POPW: begin
					// stk_rd_q holds the ticket chosen at this depth
					used_q[stk_rd_q] <= 1'b0;
					idx_q <= IW'(stk_rd_q) + 1'b1;
					state_q <= S_POPD;
				end
				S_POPD: begin
					// back at the ticket's origin; skip equal destinations
					cur_q <= rd_org_q;
					skipd_q <= rd_dst_q;
					state_q <= S_SKIP;
				end
				S_SKIP: begin
					if ((idx_q < cnt_q) && (rd_dst_q == skipd_q)) idx_q <= idx_q + 1'b1;
					else state_q <= S_RD;
				end
				S_EMIT: begin
					if (dep_q == '0) begin
						if (out_free) dep_q <= dep_q + 1'b1;
					end else state_q <= S_EMS;
				end
				S_EMS: state_q <= S_EMD;
				S_EMD: if (out_free) begin
					if (emit_last) begin
						cnt_q <= '0; ovf_q <= 1'b0; used_q <= '0; dep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						dep_q <= dep_q + 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_STAT: if (out_free) begin
					cnt_q <= '0; ovf_q <= 1'b0; used_q <= '0; dep_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast));
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Cap);
	a_dep_range: assert property (@(posedge clk) disable iff (!arst_n)
		dep_q <= cnt_q);
endmodule

// ----- tb/sv/tb_itinerary_backtracking_search.sv -----
// ----------------------------------------------------------------------------
// Itinerary backtracking search testbench
// Streams ticket loads into the block: directed corner cases first, then
// random well-formed itineraries mixed with broken loads and bare items.
// Every load is run through a behavioral search, and each airport result
// is checked field by field. The start airport is changed between groups of loads.
// ----------------------------------------------------------------------------
module tb_itinerary_backtracking_search;
	import ibs_pkg::*;

	localparam int Cap = 32;
	localparam int StallLimit = 2000000;

	typedef struct {
		bit [23:0] org;
		bit [23:0] dst;
		bit        has_ticket;
		bit        fin;
	} load_item_t;

	typedef struct {
		bit [23:0] code;
		bit [1:0]  status;
		bit        dropped;
		bit        last;
	} hop_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [23:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	load_item_t pending_tickets[$];
	load_item_t on_bus;
	hop_t       hops_due[$];

	bit [23:0] org_tab[Cap];
	bit [23:0] dst_tab[Cap];
	bit        taken[Cap];
	int        pick[Cap];
	int        n_loaded;
	bit        overflow;
	bit [23:0] start_code;

	int mismatches;
	int hops_seen;
	int loads_done;
	int items_sent;
	int idle_cycles;
	int cyc;
	bit [23:0] pool[4];

	itinerary_backtracking_search i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void file_ticket(bit [23:0] o, bit [23:0] d);
		int pos;
		if (n_loaded >= Cap) begin
			overflow = 1'b1;
			return;
		end
		pos = n_loaded;
		while (pos > 0 && dst_tab[pos-1] > d) begin
			org_tab[pos] = org_tab[pos-1];
			dst_tab[pos] = dst_tab[pos-1];
			pos--;
		end
		org_tab[pos] = o;
		dst_tab[pos] = d;
		n_loaded++;
	endfunction

	function automatic bit [23:0] stop_at(int depth);
		return (depth == 0) ? start_code : dst_tab[pick[depth-1]];
	endfunction

	function automatic bit find_route();
		int depth;
		int nxt;
		int i;
		int j;
		bit [23:0] here;
		depth = 0;
		nxt = 0;
		for (i = 0; i < Cap; i++)
			taken[i] = 1'b0;
		while (1) begin
			if (depth >= n_loaded)
				return 1'b1;
			here = stop_at(depth);
			for (i = nxt; i < n_loaded; i++)
				if (!taken[i] && org_tab[i] == here)
					break;
			if (i < n_loaded) begin
				taken[i] = 1'b1;
				pick[depth] = i;
				depth++;
				nxt = 0;
			end else begin
				if (depth == 0)
					return 1'b0;
				depth--;
				j = pick[depth];
				taken[j] = 1'b0;
				nxt = j + 1;
				while (nxt < n_loaded && dst_tab[nxt] == dst_tab[j])
					nxt++;
			end
		end
	endfunction

	function automatic void predict_hops(load_item_t it);
		hop_t h;
		if (it.has_ticket)
			file_ticket(it.org, it.dst);
		if (!it.fin)
			return;
		h.dropped = overflow;
		if (n_loaded == 0) begin
			h.code = '0; h.status = StEmpty; h.last = 1'b1;
			hops_due.push_back(h);
		end else if (!find_route()) begin
			h.code = '0; h.status = StNoPath; h.last = 1'b1;
			hops_due.push_back(h);
		end else begin
			for (int d = 0; d <= n_loaded; d++) begin
				h.code = stop_at(d); h.status = StFound; h.last = (d == n_loaded);
				hops_due.push_back(h);
			end
		end
		n_loaded = 0;
		overflow = 1'b0;
		loads_done++;
	endfunction

	// driver and result-side ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
			m_axis_tready <= 1'b0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			m_axis_tready <= (cyc % 4000 < 700) || ($urandom_range(99) >= 13);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid) begin
					predict_hops(on_bus);
					items_sent++;
				end
				if (pending_tickets.size() > 0 &&
				    ((cyc % 4000 < 700) || $urandom_range(99) >= 13)) begin
					on_bus = pending_tickets.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {on_bus.dst, on_bus.org};
					s_axis_tuser <= on_bus.has_ticket;
					s_axis_tlast <= on_bus.fin;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		hop_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			hops_seen++;
			if (hops_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: code=%h status=%0d dropped=%b last=%b",
						m_axis_tdata[23:0], m_axis_tdata[25:24], m_axis_tdata[26],
						m_axis_tlast);
			end else begin
				want = hops_due.pop_front();
				if (m_axis_tdata[23:0] !== want.code || m_axis_tdata[25:24] !== want.status ||
				    m_axis_tdata[26] !== want.dropped || m_axis_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp code=%h st=%0d drop=%b last=%b, got %h %0d %b %b",
							want.code, want.status, want.dropped, want.last,
							m_axis_tdata[23:0], m_axis_tdata[25:24], m_axis_tdata[26],
							m_axis_tlast);
				end
			end
		end
	end

	// watchdog on transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > StallLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic add(bit [23:0] o, bit [23:0] d, bit tp, bit fin);
		load_item_t it;
		it.org = o; it.dst = d; it.has_ticket = tp; it.fin = fin;
		pending_tickets.push_back(it);
	endtask

	task automatic drain_and_set_start(bit [23:0] code);
		while (pending_tickets.size() > 0 || s_axis_tvalid || hops_due.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		start_code = code;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// a shuffled walk from the start airport, optionally with a stray ticket
	task automatic walk_load(int n, bit broken);
		load_item_t walk[$];
		load_item_t it;
		bit [23:0] here;
		int k;
		here = start_code;
		for (int i = 0; i < n; i++) begin
			it.org = here;
			it.dst = pool[$urandom_range(3)];
			it.has_ticket = 1'b1;
			it.fin = 1'b0;
			here = it.dst;
			walk.push_back(it);
		end
		if (broken) begin
			it.org = pool[$urandom_range(3)];
			it.dst = 24'($urandom);
			walk.push_back(it);
		end
		walk.shuffle();
		for (int i = 0; i < walk.size(); i++) begin
			if ($urandom_range(9) == 0)
				add(24'($urandom), 24'($urandom), 1'b0, 1'b0);
			pending_tickets.push_back(walk[i]);
		end
		k = $urandom_range(2);
		if (k == 0) begin
			add(24'($urandom), 24'($urandom), 1'b0, 1'b1);
		end else begin
			it = pending_tickets.pop_back();
			it.fin = 1'b1;
			pending_tickets.push_back(it);
		end
	endtask

	initial begin
		bit [23:0] c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mismatches = 0; hops_seen = 0; loads_done = 0; items_sent = 0; idle_cycles = 0;
		n_loaded = 0; overflow = 1'b0; start_code = DefStart;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty load, then a single round trip from the default start
		add(24'hFFFFFF, 24'h000000, 1'b0, 1'b1);
		add(DefStart, 24'h4A464B, 1'b1, 1'b0);
		add(24'h4A464B, DefStart, 1'b1, 1'b1);
		// ticket not leaving the start: no itinerary
		add(24'h000000, 24'hFFFFFF, 1'b1, 1'b1);
		// duplicate tickets and a dead-end branch that forces a backtrack
		add(DefStart, 24'h000001, 1'b1, 1'b0);
		add(DefStart, 24'h000002, 1'b1, 1'b0);
		add(24'h000002, DefStart, 1'b1, 1'b0);
		add(DefStart, 24'h000002, 1'b1, 1'b0);
		add(24'h000002, DefStart, 1'b1, 1'b1);
		// long chain past capacity: last tickets are dropped
		for (int k = 0; k < Cap + 2; k++)
			add(24'(k == 0 ? DefStart : 24'h100000 + k), 24'(24'h100001 + k), 1'b1,
				k == Cap + 1);

		drain_and_set_start(24'h000000);
		add(24'h000000, 24'h000000, 1'b1, 1'b0);
		add(24'h000000, 24'hFFFFFF, 1'b1, 1'b1);
		drain_and_set_start(24'hFFFFFF);
		add(24'hFFFFFF, 24'h000000, 1'b1, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: c = 24'($urandom);
				1: c = 24'hFFFFFF;
				2: c = 24'h000000;
				default: c = DefStart;
			endcase
			drain_and_set_start(c);
			for (int l = 0; l < 12; l++) begin
				for (int p = 0; p < 4; p++)
					pool[p] = ($urandom_range(3) == 0) ? 24'($urandom) : 24'(24'h41_41_40 + p);
				if ($urandom_range(5) == 0)
					add(24'($urandom), 24'($urandom), 1'($urandom_range(1)), 1'b1);
				else
					walk_load($urandom_range(1, 7), $urandom_range(4) == 0);
			end
		end

		while (pending_tickets.size() > 0 || s_axis_tvalid || hops_due.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d load items in %0d searches, checked %0d results",
			items_sent, loads_done, hops_seen);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
